/* sv/bad_pkg.sv */
// shared constants, types and division handshake structs for the box area downscaler
`default_nettype none

package bad_pkg;

    // image limits and field widths
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = 11;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 4;
    localparam int CH_IDX_W   = 2;
    localparam int OUT_XY_W   = 10;

    // accumulator and division widths
    localparam int CNT_W      = COL_W + ROW_W + 1;
    localparam int SUM_W      = CNT_W + CH_W - 1;
    localparam int NUM_W      = SUM_W + 1;
    localparam int QUO_W      = DIM_W;
    localparam int NB_W       = $clog2(QUO_W + 1);

    // stream data widths
    localparam int S_TDATA_W  = NUM_CH * CH_W;
    localparam int M_FIELD_W  = NUM_CH * CH_W + 2 * OUT_XY_W;
    localparam int M_TDATA_W  = ((M_FIELD_W + 7) / 8) * 8;

    // configuration register indexes
    localparam int CFG_AW     = 2;
    localparam logic [CFG_AW-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_AW-1:0] REG_TARGET_WIDTH  = 2'd2;
    localparam logic [CFG_AW-1:0] REG_TARGET_HEIGHT = 2'd3;

    // register reset values
    localparam logic [DIM_W-1:0] RST_SOURCE_WIDTH  = 11'd256;
    localparam logic [DIM_W-1:0] RST_SOURCE_HEIGHT = 11'd256;
    localparam logic [DIM_W-1:0] RST_TARGET_WIDTH  = 11'd64;
    localparam logic [DIM_W-1:0] RST_TARGET_HEIGHT = 11'd64;

    // request into the shared divider: divisor comes pre-shifted to the top quotient bit
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] dsh;
        logic [NB_W-1:0]  nbits;
    } div_req_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quot;
    } div_rsp_t;

endpackage

`default_nettype wire

/* sv/box_area_downscale_rgba_top.sv */
// box filter area averaging rgba downscaler, top level
//
//  channel  | direction | transfer when       | contents
//  s_       | in        | s_tvalid & s_tready | source pixel, raster order
//  m_       | out       | m_tvalid & m_tready | averaged pixel with position, tlast ends frame
//  cfg_     | in        | cfg_wr_en           | size registers, any write restarts the frame
//
//  a pixel inside a band passes through the idle, read, update and output states;
//  crossing a column or row band boundary adds one 11-bit division, and closing a
//  destination pixel adds four 8-bit divisions on the shared divider
//  after reset and after every register write the first band boundaries are divided
//  out, during which s_tready stays low
//  one result register decouples the output; the block waits only when a new result
//  is ready and the previous one has not been taken
`default_nettype none

module box_area_downscale_rgba_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // in_red [7:0], in_green [15:8], in_blue [23:16], in_alpha [31:24]
    input  wire logic [bad_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // out_red [7:0], out_green [15:8], out_blue [23:16], out_alpha [31:24],
    // out_x [41:32], out_y [51:42], zero fill above
    output logic [bad_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                 m_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            cfg_wr_en,
    input  wire logic [bad_pkg::CFG_AW-1:0]      cfg_addr,
    input  wire logic [bad_pkg::DIM_W-1:0]       cfg_wdata
);
    import bad_pkg::*;

    // sequencer states
    localparam logic [3:0] ST_INIT_C0 = 4'd0;
    localparam logic [3:0] ST_INIT_C1 = 4'd1;
    localparam logic [3:0] ST_INIT_R0 = 4'd2;
    localparam logic [3:0] ST_INIT_R1 = 4'd3;
    localparam logic [3:0] ST_IDLE    = 4'd4;
    localparam logic [3:0] ST_READ    = 4'd5;
    localparam logic [3:0] ST_DSTART  = 4'd6;
    localparam logic [3:0] ST_DWAIT   = 4'd7;
    localparam logic [3:0] ST_UPD     = 4'd8;
    localparam logic [3:0] ST_BWAIT   = 4'd9;
    localparam logic [3:0] ST_OUT     = 4'd10;

    localparam logic [CH_IDX_W-1:0] LAST_CH = CH_IDX_W'(NUM_CH - 1);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // state
    logic [3:0]          st_reg, st_next;
    logic [DIM_W-1:0]    src_w_reg, src_w_next, src_h_reg, src_h_next;
    logic [DIM_W-1:0]    dst_w_reg, dst_w_next, dst_h_reg, dst_h_next;
    logic [COL_W-1:0]    src_col_reg, src_col_next, dst_col_reg, dst_col_next;
    logic [ROW_W-1:0]    src_row_reg, src_row_next, dst_row_reg, dst_row_next;
    logic [DIM_W-1:0]    col_start_reg, col_start_next, col_end_reg, col_end_next;
    logic [DIM_W-1:0]    row_start_reg, row_start_next, row_end_reg, row_end_next;
    logic [DIM_W-1:0]    col_first_reg, col_first_next, row_first_reg, row_first_next;
    logic [CH_IDX_W-1:0] ch_reg, ch_next;
    logic                bsel_row_reg, bsel_row_next;
    logic                m_tvalid_reg, m_tvalid_next;

    // payload
    logic [S_TDATA_W-1:0]      pix_reg;
    logic [NUM_CH*SUM_W-1:0]   rd_reg;
    logic [SUM_W-1:0]          sum_reg [NUM_CH];
    logic [CH_W-1:0]           res_reg [NUM_CH];
    logic [CNT_W-1:0]          count_reg;
    logic                      emit_reg, last_reg;
    logic [OUT_XY_W-1:0]       ox_reg, oy_reg;
    logic [M_TDATA_W-1:0]      m_tdata_reg;
    logic                      m_tlast_reg;
    logic [NUM_CH*SUM_W-1:0]   sum_mem [MAX_WIDTH];

    // combinational
    logic [DIM_W-1:0]          sw_eff, sh_eff, dw_eff, dh_eff;
    logic                      accept, first_px, emit_now, frame_last, load_out;
    logic [NUM_CH*SUM_W-1:0]   new_sums;
    logic [2*DIM_W-1:0]        count_prod, bprod;
    logic [DIM_W-1:0]          c1, r1, k_sel, s_sel, d_sel;
    logic                      need_div, need_row;
    div_req_t                  div_req;
    div_rsp_t                  div_rsp;

    // effective sizes
    assign sw_eff = clamp_dim(src_w_reg, DIM_W'(MAX_WIDTH));
    assign sh_eff = clamp_dim(src_h_reg, DIM_W'(MAX_HEIGHT));
    assign dw_eff = clamp_dim(dst_w_reg, sw_eff);
    assign dh_eff = clamp_dim(dst_h_reg, sh_eff);

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (st_reg == ST_IDLE);

    // first pixel of a band starts its accumulator from zero
    assign first_px = (DIM_W'(src_col_reg) == col_start_reg) &&
                      (DIM_W'(src_row_reg) == row_start_reg);
    assign emit_now = (DIM_W'(src_col_reg) + DIM_W'(1) == col_end_reg) &&
                      (DIM_W'(src_row_reg) + DIM_W'(1) == row_end_reg);
    assign frame_last = (DIM_W'(dst_col_reg) + DIM_W'(1) == dw_eff) &&
                        (DIM_W'(dst_row_reg) + DIM_W'(1) == dh_eff);
    assign count_prod = (2*DIM_W)'(col_end_reg - col_start_reg) *
                        (2*DIM_W)'(row_end_reg - row_start_reg);

    // accumulate the pixel into the band sums
    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            new_sums[i*SUM_W +: SUM_W] =
                (first_px ? SUM_W'(0) : rd_reg[i*SUM_W +: SUM_W]) +
                SUM_W'(pix_reg[i*CH_W +: CH_W]);
        end
    end

    // counter advance after a pixel
    always_comb begin
        c1       = DIM_W'(src_col_reg) + DIM_W'(1);
        r1       = DIM_W'(src_row_reg) + DIM_W'(1);
        need_div = 1'b0;
        need_row = 1'b0;
        if (c1 >= sw_eff) begin
            if ((r1 < sh_eff) && (r1 >= row_end_reg)) begin
                need_div = 1'b1;
                need_row = 1'b1;
            end
        end else if (c1 >= col_end_reg) begin
            need_div = 1'b1;
        end
        k_sel = need_row ? DIM_W'(dst_row_reg) + DIM_W'(2) : DIM_W'(dst_col_reg) + DIM_W'(2);
        s_sel = need_row ? sh_eff : sw_eff;
        d_sel = need_row ? dh_eff : dw_eff;
        bprod = (2*DIM_W)'(k_sel) * (2*DIM_W)'(s_sel);
    end

    assign load_out = (st_reg == ST_OUT) && emit_reg && (!m_tvalid_reg || m_tready);

    // divider requests
    always_comb begin
        div_req = '0;
        case (st_reg)
            ST_INIT_C0: begin
                div_req.start = 1'b1;
                div_req.num   = NUM_W'(sw_eff);
                div_req.dsh   = NUM_W'(dw_eff) << (QUO_W - 1);
                div_req.nbits = NB_W'(QUO_W);
            end
            ST_INIT_R0: begin
                div_req.start = 1'b1;
                div_req.num   = NUM_W'(sh_eff);
                div_req.dsh   = NUM_W'(dh_eff) << (QUO_W - 1);
                div_req.nbits = NB_W'(QUO_W);
            end
            ST_DSTART: begin
                div_req.start = 1'b1;
                div_req.num   = {sum_reg[ch_reg], 1'b0} + NUM_W'(count_reg);
                div_req.dsh   = NUM_W'(count_reg) << CH_W;
                div_req.nbits = NB_W'(CH_W);
            end
            ST_UPD: begin
                div_req.start = need_div;
                div_req.num   = NUM_W'(bprod);
                div_req.dsh   = NUM_W'(d_sel) << (QUO_W - 1);
                div_req.nbits = NB_W'(QUO_W);
            end
            default: begin
                div_req = '0;
            end
        endcase
    end

    bad_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // sequencer and counters
    always_comb begin
        st_next        = st_reg;
        src_w_next     = src_w_reg;
        src_h_next     = src_h_reg;
        dst_w_next     = dst_w_reg;
        dst_h_next     = dst_h_reg;
        src_col_next   = src_col_reg;
        src_row_next   = src_row_reg;
        dst_col_next   = dst_col_reg;
        dst_row_next   = dst_row_reg;
        col_start_next = col_start_reg;
        col_end_next   = col_end_reg;
        row_start_next = row_start_reg;
        row_end_next   = row_end_reg;
        col_first_next = col_first_reg;
        row_first_next = row_first_reg;
        ch_next        = ch_reg;
        bsel_row_next  = bsel_row_reg;
        m_tvalid_next  = m_tvalid_reg;

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (load_out) begin
            m_tvalid_next = 1'b1;
        end

        case (st_reg)
            ST_INIT_C0: st_next = ST_INIT_C1;
            ST_INIT_C1: begin
                if (div_rsp.done) begin
                    col_first_next = div_rsp.quot;
                    col_end_next   = div_rsp.quot;
                    st_next        = ST_INIT_R0;
                end
            end
            ST_INIT_R0: st_next = ST_INIT_R1;
            ST_INIT_R1: begin
                if (div_rsp.done) begin
                    row_first_next = div_rsp.quot;
                    row_end_next   = div_rsp.quot;
                    st_next        = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    st_next = ST_READ;
                end
            end
            ST_READ: begin
                ch_next = '0;
                st_next = emit_now ? ST_DSTART : ST_UPD;
            end
            ST_DSTART: st_next = ST_DWAIT;
            ST_DWAIT: begin
                if (div_rsp.done) begin
                    if (ch_reg == LAST_CH) begin
                        st_next = ST_UPD;
                    end else begin
                        ch_next = ch_reg + CH_IDX_W'(1);
                        st_next = ST_DSTART;
                    end
                end
            end
            ST_UPD: begin
                bsel_row_next = need_row;
                st_next       = need_div ? ST_BWAIT : ST_OUT;
                if (c1 >= sw_eff) begin
                    src_col_next   = '0;
                    dst_col_next   = '0;
                    col_start_next = '0;
                    col_end_next   = col_first_reg;
                    if (r1 >= sh_eff) begin
                        src_row_next   = '0;
                        dst_row_next   = '0;
                        row_start_next = '0;
                        row_end_next   = row_first_reg;
                    end else begin
                        src_row_next = r1[ROW_W-1:0];
                        if (r1 >= row_end_reg) begin
                            dst_row_next   = dst_row_reg + ROW_W'(1);
                            row_start_next = row_end_reg;
                        end
                    end
                end else begin
                    src_col_next = c1[COL_W-1:0];
                    if (c1 >= col_end_reg) begin
                        dst_col_next   = dst_col_reg + COL_W'(1);
                        col_start_next = col_end_reg;
                    end
                end
            end
            ST_BWAIT: begin
                if (div_rsp.done) begin
                    if (bsel_row_reg) begin
                        row_end_next = div_rsp.quot;
                    end else begin
                        col_end_next = div_rsp.quot;
                    end
                    st_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!emit_reg || load_out) begin
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_INIT_C0;
        endcase

        // register write restarts the frame
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SOURCE_WIDTH:  src_w_next = cfg_wdata;
                REG_SOURCE_HEIGHT: src_h_next = cfg_wdata;
                REG_TARGET_WIDTH:  dst_w_next = cfg_wdata;
                REG_TARGET_HEIGHT: dst_h_next = cfg_wdata;
                default:           src_w_next = src_w_reg;
            endcase
            src_col_next   = '0;
            src_row_next   = '0;
            dst_col_next   = '0;
            dst_row_next   = '0;
            col_start_next = '0;
            row_start_next = '0;
            st_next        = ST_INIT_C0;
        end
    end

    // control flops
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_INIT_C0;
            src_w_reg     <= RST_SOURCE_WIDTH;
            src_h_reg     <= RST_SOURCE_HEIGHT;
            dst_w_reg     <= RST_TARGET_WIDTH;
            dst_h_reg     <= RST_TARGET_HEIGHT;
            src_col_reg   <= '0;
            src_row_reg   <= '0;
            dst_col_reg   <= '0;
            dst_row_reg   <= '0;
            col_start_reg <= '0;
            col_end_reg   <= '0;
            row_start_reg <= '0;
            row_end_reg   <= '0;
            col_first_reg <= '0;
            row_first_reg <= '0;
            ch_reg        <= '0;
            bsel_row_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            st_reg        <= st_next;
            src_w_reg     <= src_w_next;
            src_h_reg     <= src_h_next;
            dst_w_reg     <= dst_w_next;
            dst_h_reg     <= dst_h_next;
            src_col_reg   <= src_col_next;
            src_row_reg   <= src_row_next;
            dst_col_reg   <= dst_col_next;
            dst_row_reg   <= dst_row_next;
            col_start_reg <= col_start_next;
            col_end_reg   <= col_end_next;
            row_start_reg <= row_start_next;
            row_end_reg   <= row_end_next;
            col_first_reg <= col_first_next;
            row_first_reg <= row_first_next;
            ch_reg        <= ch_next;
            bsel_row_reg  <= bsel_row_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // column accumulator memory, one row of four sums per destination column
    always_ff @(posedge aclk) begin
        if (st_reg == ST_READ) begin
            sum_mem[dst_col_reg] <= new_sums;
        end
        if (accept) begin
            rd_reg <= sum_mem[dst_col_reg];
        end
    end

    // pixel capture, divide operands, results and output register
    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg <= s_tdata;
        end
        if (st_reg == ST_READ) begin
            for (int i = 0; i < NUM_CH; i++) begin
                sum_reg[i] <= new_sums[i*SUM_W +: SUM_W];
            end
            count_reg <= CNT_W'(count_prod);
            emit_reg  <= emit_now;
            last_reg  <= frame_last;
            ox_reg    <= OUT_XY_W'(dst_col_reg);
            oy_reg    <= OUT_XY_W'(dst_row_reg);
        end
        if ((st_reg == ST_DWAIT) && div_rsp.done) begin
            res_reg[ch_reg] <= div_rsp.quot[CH_W-1:0];
        end
        if (load_out) begin
            m_tdata_reg <= M_TDATA_W'({oy_reg, ox_reg,
                                       res_reg[3], res_reg[2], res_reg[1], res_reg[0]});
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTH
    a_idle_in_col_band: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_IDLE) |->
            ((DIM_W'(src_col_reg) < col_end_reg) && (col_start_reg <= DIM_W'(src_col_reg))))
        else $error("source column outside its band while idle");

    a_idle_dst_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_IDLE) |->
            ((DIM_W'(dst_col_reg) < dw_eff) && (DIM_W'(dst_row_reg) < dh_eff)))
        else $error("destination position beyond target size");

    a_div_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |->
            (st_reg == ST_INIT_C0 || st_reg == ST_INIT_C1 || st_reg == ST_INIT_R1 ||
             st_reg == ST_DWAIT || st_reg == ST_BWAIT))
        else $error("divider finished with no waiting state");
`endif

endmodule

`default_nettype wire

/* sv/bad_div.sv */
// shared restoring divider, one quotient bit per cycle
`default_nettype none

module bad_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire bad_pkg::div_req_t req,
    output bad_pkg::div_rsp_t      rsp
);
    import bad_pkg::*;

    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] dsh_reg, dsh_next;
    logic [QUO_W-1:0] quot_reg, quot_next;
    logic [NB_W-1:0]  cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [NUM_W:0]   diff;
    logic             ge;

    // trial subtract of the shifted divisor
    assign diff = {1'b0, rem_reg} - {1'b0, dsh_reg};
    assign ge   = ~diff[NUM_W];

    // iteration control
    always_comb begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = req.num;
            dsh_next  = req.dsh;
            quot_next = '0;
            cnt_next  = req.nbits;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (ge) begin
                rem_next = diff[NUM_W-1:0];
            end
            quot_next = {quot_reg[QUO_W-2:0], ge};
            dsh_next  = dsh_reg >> 1;
            cnt_next  = cnt_reg - NB_W'(1);
            if (cnt_reg == NB_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control flops
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath flops
    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
        cnt_reg  <= cnt_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

`default_nettype wire

/* sim/tb.sv */
// self-checking testbench for the box area averaging rgba downscaler
`timescale 1ns / 100ps

module tb;
    import bad_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int SETTLE_CYCLES = 80;
    localparam int RANDOM_ITEMS  = 620;
    localparam int CYCLE_LIMIT   = 500000;

    // source pixel as packed on s_tdata, red in the lowest byte
    typedef struct packed {
        logic [CH_W-1:0] alpha;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } rgba_t;

    // destination pixel as packed on m_tdata, with tlast on top
    typedef struct packed {
        logic                last;
        logic [OUT_XY_W-1:0] y;
        logic [OUT_XY_W-1:0] x;
        logic [CH_W-1:0]     alpha;
        logic [CH_W-1:0]     blue;
        logic [CH_W-1:0]     green;
        logic [CH_W-1:0]     red;
    } avg_pixel_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_AW-1:0]    cfg_addr  = '0;
    logic [DIM_W-1:0]     cfg_wdata = '0;

    box_area_downscale_rgba_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // averages still to come out, oldest first
    avg_pixel_t awaited_averages[$];

    int unsigned error_count = 0;
    int unsigned sent_count  = 0;
    int unsigned cycle_count = 0;
    int unsigned sink_wait   = 0;
    bit          no_idle     = 1'b0;

    // size registers as written
    int unsigned size_src_w, size_src_h, size_dst_w, size_dst_h;

    // per-column band sums and raster position
    int unsigned band_red[MAX_WIDTH], band_green[MAX_WIDTH];
    int unsigned band_blue[MAX_WIDTH], band_alpha[MAX_WIDTH];
    int unsigned col_pos, row_pos, out_col, out_row;
    int unsigned col_lo, col_hi, row_lo, row_hi;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned eff_src_w();
        return clamp_dim(size_src_w, MAX_WIDTH);
    endfunction

    function automatic int unsigned eff_src_h();
        return clamp_dim(size_src_h, MAX_HEIGHT);
    endfunction

    function automatic int unsigned eff_dst_w();
        return clamp_dim(size_dst_w, eff_src_w());
    endfunction

    function automatic int unsigned eff_dst_h();
        return clamp_dim(size_dst_h, eff_src_h());
    endfunction

    // first source index of destination band k
    function automatic int unsigned band_edge(int unsigned k, int unsigned s, int unsigned d);
        return 32'((64'(k) * 64'(s)) / 64'(d));
    endfunction

    // round half up, saturate to a byte
    function automatic logic [CH_W-1:0] round_avg(int unsigned total, longint unsigned count);
        longint unsigned v;
        v = (64'd2 * 64'(total) + count) / (64'd2 * count);
        return (v > 255) ? 8'hFF : v[CH_W-1:0];
    endfunction

    function automatic void restart_frame();
        for (int i = 0; i < MAX_WIDTH; i++) begin
            band_red[i]   = 0;
            band_green[i] = 0;
            band_blue[i]  = 0;
            band_alpha[i] = 0;
        end
        col_pos = 0;
        row_pos = 0;
        out_col = 0;
        out_row = 0;
        col_lo  = 0;
        col_hi  = band_edge(1, eff_src_w(), eff_dst_w());
        row_lo  = 0;
        row_hi  = band_edge(1, eff_src_h(), eff_dst_h());
    endfunction

    function automatic void apply_reg(logic [CFG_AW-1:0] idx, int unsigned value);
        int unsigned v;
        v = value & 32'h7FF;
        case (idx)
            REG_SOURCE_WIDTH:  size_src_w = v;
            REG_SOURCE_HEIGHT: size_src_h = v;
            REG_TARGET_WIDTH:  size_dst_w = v;
            REG_TARGET_HEIGHT: size_dst_h = v;
            default: return;
        endcase
        restart_frame();
    endfunction

    // add one source pixel to its band, queue the average when the band closes
    function automatic void accumulate_pixel(rgba_t pix);
        int unsigned sw, sh, dw, dh;
        longint unsigned count;
        avg_pixel_t avg;
        sw = eff_src_w();
        sh = eff_src_h();
        dw = eff_dst_w();
        dh = eff_dst_h();
        band_red[out_col]   += pix.red;
        band_green[out_col] += pix.green;
        band_blue[out_col]  += pix.blue;
        band_alpha[out_col] += pix.alpha;

        if (col_pos + 1 == col_hi && row_pos + 1 == row_hi) begin
            count = 64'(col_hi - col_lo) * 64'(row_hi - row_lo);
            if (count == 0) count = 1;
            avg.red   = round_avg(band_red[out_col], count);
            avg.green = round_avg(band_green[out_col], count);
            avg.blue  = round_avg(band_blue[out_col], count);
            avg.alpha = round_avg(band_alpha[out_col], count);
            avg.x     = out_col[OUT_XY_W-1:0];
            avg.y     = out_row[OUT_XY_W-1:0];
            avg.last  = (out_col + 1 == dw) && (out_row + 1 == dh);
            awaited_averages = {awaited_averages, avg};
            band_red[out_col]   = 0;
            band_green[out_col] = 0;
            band_blue[out_col]  = 0;
            band_alpha[out_col] = 0;
        end

        // advance the raster position and the bands
        col_pos++;
        if (col_pos >= sw) begin
            col_pos = 0;
            out_col = 0;
            col_lo  = 0;
            col_hi  = band_edge(1, sw, dw);
            row_pos++;
            if (row_pos >= sh) begin
                row_pos = 0;
                out_row = 0;
                row_lo  = 0;
                row_hi  = band_edge(1, sh, dh);
            end else if (row_pos >= row_hi) begin
                out_row++;
                row_lo = row_hi;
                row_hi = band_edge(out_row + 1, sh, dh);
            end
        end else if (col_pos >= col_hi) begin
            out_col++;
            col_lo = col_hi;
            col_hi = band_edge(out_col + 1, sw, dw);
        end
    endfunction

    // one source transfer after a random gap; tvalid stays high for a back-to-back item
    task automatic send_pixel(input rgba_t pix);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        accumulate_pixel(pix);
        sent_count++;
    endtask

    // stop sending, let all averages drain and the block go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (awaited_averages.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input int unsigned value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value[DIM_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        apply_reg(idx, value);
    endtask

    task automatic set_sizes(input int unsigned sw, input int unsigned sh,
                             input int unsigned dw, input int unsigned dh);
        settle();
        write_reg(REG_SOURCE_WIDTH, sw);
        write_reg(REG_SOURCE_HEIGHT, sh);
        write_reg(REG_TARGET_WIDTH, dw);
        write_reg(REG_TARGET_HEIGHT, dh);
    endtask

    // partial sums from a frame cut short by a write must not leak
    task automatic test_restart_mid_frame();
        repeat (4) send_pixel(32'hFFFF_FFFF);
        set_sizes(2, 2, 1, 1);
        send_pixel(32'h0000_0000);
        send_pixel(32'h0102_0304);
        send_pixel(32'h8040_2010);
        send_pixel(32'hFE7F_01FF);
    endtask

    // zero sizes act as one: every pixel is its own frame
    task automatic test_unit_frame();
        set_sizes(0, 0, 0, 0);
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'hAA55_AA55);
        send_pixel(32'h55AA_55AA);
    endtask

    // uneven bands of one and two columns, halves round up
    task automatic test_rounding();
        set_sizes(3, 1, 2, 1);
        send_pixel(32'h0000_0000);
        send_pixel(32'h0100_FF00);
        send_pixel(32'h0001_FE01);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'hFE02_0000);
        send_pixel(32'hFF03_0001);
    endtask

    // sizes beyond the maximum and targets above the source are clamped
    task automatic test_clamped_sizes();
        set_sizes(2047, 2047, 2047, 2047);
        repeat (4) send_pixel(rgba_t'($urandom));
        set_sizes(3, 2, 9, 5);
        repeat (6) send_pixel(rgba_t'($urandom));
    endtask

    // random small frames, mostly complete, some cut short
    task automatic test_random_frames();
        int unsigned sw, sh, dw, dh, frame_px, n_px, stop_at;
        rgba_t pix;
        stop_at = sent_count + RANDOM_ITEMS;
        while (sent_count < stop_at) begin
            sw = $urandom_range(1, 12);
            sh = $urandom_range(1, 6);
            dw = $urandom_range(1, sw);
            dh = $urandom_range(1, sh);
            case ($urandom_range(0, 11))
                0: dw = 2047;
                1: dh = sh + $urandom_range(1, 4);
                2: begin
                    sh = 0;
                    dh = 0;
                end
                3: begin
                    sw = 1024 + $urandom_range(0, 1023);
                    dw = $urandom_range(1020, 2047);
                    sh = 1;
                    dh = 1;
                end
                default: ;
            endcase
            set_sizes(sw, sh, dw, dh);
            no_idle  = ($urandom_range(0, 3) == 0);
            frame_px = eff_src_w() * eff_src_h();
            if (frame_px <= 72 && $urandom_range(0, 4) != 0)
                n_px = frame_px * $urandom_range(1, 3);
            else
                n_px = $urandom_range(1, (frame_px < 40) ? frame_px : 40);
            repeat (n_px) begin
                pix = $urandom;
                case ($urandom_range(0, 9))
                    0: pix = 32'hFFFF_FFFF;
                    1: pix = 32'h0000_0000;
                    default: ;
                endcase
                send_pixel(pix);
            end
            no_idle = 1'b0;
        end
    endtask

    // output side: random stall after each transfer, compare with the oldest average
    always @(posedge aclk) begin
        avg_pixel_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tlast, m_tdata[M_FIELD_W-1:0]};
            if (awaited_averages.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected output pixel x=%0d y=%0d rgba=%h %h %h %h last=%0b",
                             got.x, got.y, got.red, got.green, got.blue, got.alpha, got.last);
            end else begin
                want = awaited_averages.pop_front();
                if (got !== want) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("mismatch expected x=%0d y=%0d rgba=%h %h %h %h last=%0b",
                                 want.x, want.y, want.red, want.green, want.blue,
                                 want.alpha, want.last);
                        $display("         actual   x=%0d y=%0d rgba=%h %h %h %h last=%0b",
                                 got.x, got.y, got.red, got.green, got.blue,
                                 got.alpha, got.last);
                    end
                end
            end
            sink_wait = no_idle ? 0 : $urandom_range(0, 5);
        end
        if (sink_wait != 0) begin
            m_tready <= 1'b0;
            sink_wait--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        size_src_w = 32'(RST_SOURCE_WIDTH);
        size_src_h = 32'(RST_SOURCE_HEIGHT);
        size_dst_w = 32'(RST_TARGET_WIDTH);
        size_dst_h = 32'(RST_TARGET_HEIGHT);
        restart_frame();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_restart_mid_frame();
        test_unit_frame();
        test_rounding();
        test_clamped_sizes();
        test_random_frames();
        settle();

        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
